// File: design/dxt_pkg.sv
// ----------------------------------------------------------------------------
// DXT block decoder package
// Shared types, constants and helper functions for the block decoder.
// ----------------------------------------------------------------------------
package dxt_pkg;

   localparam int DEFAULT_MAX_DIMENSION = 8192;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 14;

   typedef enum logic [1:0] {
      CSR_DXT_MODE     = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_DXT1 = 2'd0,
      MODE_DXT3 = 2'd1,
      MODE_DXT5 = 2'd2,
      MODE_ALT5 = 2'd3
   } mode_type;

   typedef struct packed {
      logic [63:0] color_word;
      logic [63:0] alpha_word;
   } req_type;

   typedef struct packed {
      logic [12:0] texel_x;
      logic [12:0] texel_y;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        block_last;
      logic        image_last;
   } rsp_type;

   // Palette of one block, as handed from the front to the back end.
   typedef struct packed {
      logic [3:0][7:0] red;
      logic [3:0][7:0] green;
      logic [3:0][7:0] blue;
      logic [7:0][7:0] alpha_table;
      logic [31:0]     indices;
      logic [63:0]     alpha_word;
      mode_type        mode;
      logic            punch;
      logic [10:0]     block_column;
      logic [10:0]     block_row;
      logic [15:0]     texel_mask;
      logic            last_block;
   } block_type;

   // Rounds v * 255 / 31 down: 8v plus 7v / 31 taken via a reciprocal.
   function automatic logic [7:0] expand5(input logic [4:0] v);
      logic [16:0] p;
      p = 17'(v) * 17'd1855;
      return {v, 3'b000} + 8'(p[16:13]);
   endfunction

   // Rounds v * 255 / 63 down: 4v plus v / 21 taken via a reciprocal.
   function automatic logic [7:0] expand6(input logic [5:0] v);
      logic [11:0] p;
      p = 12'(v) * 12'd49;
      return {v, 2'b00} + 8'(p[11:10]);
   endfunction

   // Division by three of a value below 768 via a reciprocal.
   function automatic logic [7:0] div3(input logic [9:0] v);
      logic [21:0] p;
      p = 22'(v) * 22'd1366;
      return p[19:12];
   endfunction

   function automatic logic [7:0] div5(input logic [10:0] v);
      logic [23:0] p;
      p = 24'(v) * 24'd3277;
      return p[21:14];
   endfunction

   function automatic logic [7:0] div7(input logic [10:0] v);
      logic [24:0] p;
      p = 25'(v) * 25'd9363;
      return p[23:16];
   endfunction

endpackage

// File: design/dxt_front.sv
// ----------------------------------------------------------------------------
// DXT front end
// Accepts blocks, builds the palettes, the clip mask and the block position.
// ----------------------------------------------------------------------------
module dxt_front import dxt_pkg::*; #(
   parameter int MAX_DIMENSION = DEFAULT_MAX_DIMENSION
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   input  mode_type          mode,
   input  logic [13:0]       width,
   input  logic [13:0]       height,
   output logic              blk_valid,
   input  logic              blk_stall,
   output block_type         blk_data
);

   localparam logic [14:0] MAXD = 15'(MAX_DIMENSION);

   logic [10:0] col_ff, col_in, row_ff, row_in;
   logic        valid_ff, valid_in;
   block_type   blk_ff, blk_in;
   logic [14:0] w, h;
   logic [12:0] bxn, byn;
   logic [10:0] col, row;
   logic        take;
   logic [15:0] c0, c1;
   logic [7:0]  r0, r1, g0, g1, b0, b1, a0, a1;

   always_comb begin
      w = (width == 14'd0) ? 15'd1 : ((15'(width) > MAXD) ? MAXD : 15'(width));
      h = (height == 14'd0) ? 15'd1 : ((15'(height) > MAXD) ? MAXD : 15'(height));
      bxn = 13'((w + 15'd3) >> 2);
      byn = 13'((h + 15'd3) >> 2);
      col = (13'(col_ff) >= bxn) ? 11'd0 : col_ff;
      row = (13'(row_ff) >= byn) ? 11'd0 : row_ff;
      take = req_valid && !req_stall;
      c0 = req_data.color_word[15:0];
      c1 = req_data.color_word[31:16];
      r0 = expand5(c0[15:11]); g0 = expand6(c0[10:5]); b0 = expand5(c0[4:0]);
      r1 = expand5(c1[15:11]); g1 = expand6(c1[10:5]); b1 = expand5(c1[4:0]);
      a0 = req_data.alpha_word[7:0];
      a1 = req_data.alpha_word[15:8];
      blk_in = blk_ff;
      blk_in.mode = mode;
      blk_in.punch = (mode == MODE_DXT1) && (c0 <= c1);
      blk_in.red[0] = r0; blk_in.red[1] = r1;
      blk_in.green[0] = g0; blk_in.green[1] = g1;
      blk_in.blue[0] = b0; blk_in.blue[1] = b1;
      if (blk_in.punch) begin
         blk_in.red[2] = 8'((9'(r0) + 9'(r1)) >> 1);
         blk_in.green[2] = 8'((9'(g0) + 9'(g1)) >> 1);
         blk_in.blue[2] = 8'((9'(b0) + 9'(b1)) >> 1);
         blk_in.red[3] = 8'd0; blk_in.green[3] = 8'd0; blk_in.blue[3] = 8'd0;
      end else begin
         blk_in.red[2] = div3({1'b0, r0, 1'b0} + 10'(r1));
         blk_in.green[2] = div3({1'b0, g0, 1'b0} + 10'(g1));
         blk_in.blue[2] = div3({1'b0, b0, 1'b0} + 10'(b1));
         blk_in.red[3] = div3(10'(r0) + {1'b0, r1, 1'b0});
         blk_in.green[3] = div3(10'(g0) + {1'b0, g1, 1'b0});
         blk_in.blue[3] = div3(10'(b0) + {1'b0, b1, 1'b0});
      end
      blk_in.alpha_table[0] = a0;
      blk_in.alpha_table[1] = a1;
      for (int i = 1; i < 7; i++) begin
         if (a0 > a1) begin
            blk_in.alpha_table[i + 1] =
               div7(11'(8 - i - 1) * 11'(a0) + 11'(i) * 11'(a1));
         end else if (i < 5) begin
            blk_in.alpha_table[i + 1] =
               div5(11'(5 - i) * 11'(a0) + 11'(i) * 11'(a1));
         end else begin
            blk_in.alpha_table[i + 1] = (i == 5) ? 8'd0 : 8'd255;
         end
      end
      blk_in.indices = req_data.color_word[63:32];
      blk_in.alpha_word = req_data.alpha_word;
      blk_in.block_column = col;
      blk_in.block_row = row;
      for (int p = 0; p < 16; p++) begin
         blk_in.texel_mask[p] = ({2'b0, col, 2'(p % 4)} < w) && ({2'b0, row, 2'(p / 4)} < h);
      end
      blk_in.last_block = (13'(col) == bxn - 13'd1) && (13'(row) == byn - 13'd1);
      col_in = col_ff;
      row_in = row_ff;
      if (take) begin
         if (13'(col) + 13'd1 >= bxn) begin
            col_in = 11'd0;
            row_in = (13'(row) + 13'd1 >= byn) ? 11'd0 : row + 11'd1;
         end else begin
            col_in = col + 11'd1;
            row_in = row;
         end
      end
      valid_in = take ? 1'b1 : (blk_stall ? valid_ff : 1'b0);
      req_stall = valid_ff && blk_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= 11'd0;
         row_ff <= 11'd0;
         valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         valid_ff <= valid_in;
      end
      if (take) begin
         blk_ff <= blk_in;
      end
   end

   assign blk_valid = valid_ff;
   assign blk_data = blk_ff;

endmodule

// File: design/dxt_queue.sv
// ----------------------------------------------------------------------------
// DXT block queue
// Two-entry queue of decoded palettes between the front and back ends.
// ----------------------------------------------------------------------------
module dxt_queue import dxt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_stall,
   input  block_type in_data,
   output logic      out_valid,
   input  logic      out_stall,
   output block_type out_data
);

   block_type   mem_ff [2];
   logic        wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   always_comb begin
      in_stall = (count_ff == 2'd2);
      out_valid = (count_ff != 2'd0);
      push = in_valid && !in_stall;
      pop = out_valid && !out_stall;
      wr_in = push ? !wr_ff : wr_ff;
      rd_in = pop ? !rd_ff : rd_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
      out_data = mem_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end

endmodule

// File: design/dxt_back.sv
// ----------------------------------------------------------------------------
// DXT back end
// Walks the sixteen texels of a block and emits those inside the image.
// ----------------------------------------------------------------------------
module dxt_back import dxt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      blk_valid,
   output logic      blk_stall,
   input  block_type blk_data,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   logic [3:0]  pos_ff, pos_in;
   logic        valid_ff, valid_in;
   rsp_type     out_ff, out_in;
   logic        emit, done, free, more;
   logic [15:0] rest;
   logic [1:0]  sel;
   logic [3:0]  nib;
   logic [2:0]  aix;
   logic [7:0]  a;

   always_comb begin
      free = !valid_ff || !rsp_stall;
      emit = blk_valid && free && blk_data.texel_mask[pos_ff];
      rest = blk_data.texel_mask >> pos_ff;
      more = (rest >> 1) != 16'd0;
      done = blk_valid && free && (!more || (pos_ff == 4'd15));
      blk_stall = !done;
      sel = blk_data.indices[2 * pos_ff +: 2];
      nib = blk_data.alpha_word[4 * pos_ff +: 4];
      aix = blk_data.alpha_word[16 + 3 * pos_ff +: 3];
      case (blk_data.mode)
         MODE_DXT1: a = (blk_data.punch && sel == 2'd3) ? 8'd0 : 8'd255;
         MODE_DXT3: a = {nib, nib};
         default:   a = blk_data.alpha_table[aix];
      endcase
      out_in = out_ff;
      if (emit) begin
         out_in.texel_x = {blk_data.block_column, pos_ff[1:0]};
         out_in.texel_y = {blk_data.block_row, pos_ff[3:2]};
         out_in.red = blk_data.red[sel];
         out_in.green = blk_data.green[sel];
         out_in.blue = blk_data.blue[sel];
         out_in.alpha = a;
         out_in.block_last = !more;
         out_in.image_last = !more && blk_data.last_block;
      end
      valid_in = emit ? 1'b1 : (free ? 1'b0 : valid_ff);
      pos_in = done ? 4'd0 : ((blk_valid && free) ? pos_ff + 4'd1 : pos_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         valid_ff <= valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = out_ff;

endmodule

// File: design/dxt_block_decoder_top.sv
// ----------------------------------------------------------------------------
// DXT block decoder
// Decodes DXT1, DXT3 and DXT5 blocks into clipped texels; mode code three decodes as DXT5.
// ----------------------------------------------------------------------------
// Path: a block is registered in the front end, then held in a queue entry, and
// each texel is registered in the back-end output. The texel walker visits every
// position of a block up to its last texel inside the image, holding while the
// result stalls; meanwhile the front end and queue accept blocks until full.
// Reset: mode DXT1, width and height 1, block position zero, queue empty.
module dxt_block_decoder_top import dxt_pkg::*; #(
   parameter int MAX_DIMENSION = DEFAULT_MAX_DIMENSION
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   mode_type    mode_ff;
   logic [13:0] width_ff, height_ff;
   logic        f_valid, f_stall, q_valid, q_stall;
   block_type   f_data, q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DXT1;
         width_ff <= 14'd1;
         height_ff <= 14'd1;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_DXT_MODE:     mode_ff <= mode_type'(csr_data[1:0]);
            CSR_IMAGE_WIDTH:  width_ff <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   dxt_front #(.MAX_DIMENSION(MAX_DIMENSION)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .mode(mode_ff), .width(width_ff), .height(height_ff),
      .blk_valid(f_valid), .blk_stall(f_stall), .blk_data(f_data)
   );

   dxt_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
      .out_valid(q_valid), .out_stall(q_stall), .out_data(q_data)
   );

   dxt_back u_back (
      .clock, .reset, .blk_valid(q_valid), .blk_stall(q_stall), .blk_data(q_data),
      .rsp_valid, .rsp_stall, .rsp_data
   );

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled texel changed");
   a_image_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.image_last |-> rsp_data.block_last)
      else $error("image_last without block_last");
   a_queue_flow: assert property (@(posedge clock) disable iff (reset)
      q_valid && !q_stall |-> q_data.texel_mask != 16'd0)
      else $error("block retired without texels");

endmodule

// File: test/dxt_block_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// DXT block decoder testbench
// Drives compressed blocks into the decoder under several image sizes and
// modes, predicts every clipped texel in the testbench and compares each
// result transfer with the oldest predicted texel. Sender and receiver idle
// and stall at random in phases, and one long receiver hold-off fills the
// decoder up.
// ----------------------------------------------------------------------------
module dxt_block_decoder_top_tb;
   import dxt_pkg::*;

   localparam int DIM_LIMIT = DEFAULT_MAX_DIMENSION;
   localparam int WATCHDOG_CYCLES = 5000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      mode_type    mode;
      logic [13:0] width;
      logic [13:0] height;
      logic [63:0] color_word;
      logic [63:0] alpha_word;
      bit          typed;
      rsp_type     texel;
   } block_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   rsp_type expected_texels[$];
   mode_type decode_mode;
   int unsigned width_reg, height_reg, column_pos, row_pos;
   int error_count = 0;
   int blocks_sent = 0;
   int texels_seen = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   dxt_block_decoder_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned widen(int unsigned v, int unsigned top);
      return v * 255 / top;
   endfunction

   function automatic int unsigned fit_dimension(int unsigned v);
      if (v == 0) return 1;
      if (v > DIM_LIMIT) return DIM_LIMIT;
      return v;
   endfunction

   task automatic predict_texels(input logic [63:0] cw, input logic [63:0] aw);
      int unsigned w, h, cols, rows, c0, c1, sel, a, x, y;
      int unsigned r[4], g[4], b[4], at[8];
      bit punch, last_block;
      int lastk;
      rsp_type t;
      w = fit_dimension(width_reg);
      h = fit_dimension(height_reg);
      cols = (w + 3) / 4;
      rows = (h + 3) / 4;
      c0 = cw[15:0];
      c1 = cw[31:16];
      punch = (decode_mode == MODE_DXT1) && (c0 <= c1);
      lastk = -1;
      if (column_pos >= cols) column_pos = 0;
      if (row_pos >= rows) row_pos = 0;
      last_block = (column_pos == cols - 1) && (row_pos == rows - 1);
      r[0] = widen(c0 >> 11, 31); g[0] = widen((c0 >> 5) & 6'h3F, 63);
      b[0] = widen(c0 & 5'h1F, 31);
      r[1] = widen(c1 >> 11, 31); g[1] = widen((c1 >> 5) & 6'h3F, 63);
      b[1] = widen(c1 & 5'h1F, 31);
      if (punch) begin
         r[2] = (r[0] + r[1]) / 2; g[2] = (g[0] + g[1]) / 2; b[2] = (b[0] + b[1]) / 2;
         r[3] = 0; g[3] = 0; b[3] = 0;
      end else begin
         r[2] = (2 * r[0] + r[1]) / 3; g[2] = (2 * g[0] + g[1]) / 3;
         b[2] = (2 * b[0] + b[1]) / 3;
         r[3] = (r[0] + 2 * r[1]) / 3; g[3] = (g[0] + 2 * g[1]) / 3;
         b[3] = (b[0] + 2 * b[1]) / 3;
      end
      at[0] = aw[7:0];
      at[1] = aw[15:8];
      if (at[0] > at[1]) begin
         for (int i = 1; i < 7; i++) at[i + 1] = ((7 - i) * at[0] + i * at[1]) / 7;
      end else begin
         for (int i = 1; i < 5; i++) at[i + 1] = ((5 - i) * at[0] + i * at[1]) / 5;
         at[6] = 0;
         at[7] = 255;
      end
      for (int i = 0; i < 16; i++) begin
         x = column_pos * 4 + (i & 3);
         y = row_pos * 4 + (i >> 2);
         if (x >= w || y >= h) continue;
         sel = (cw >> (32 + 2 * i)) & 2'h3;
         if (decode_mode == MODE_DXT1) a = (punch && sel == 3) ? 0 : 255;
         else if (decode_mode == MODE_DXT3) a = ((aw >> (4 * i)) & 4'hF) * 255 / 15;
         else a = at[(aw >> (16 + 3 * i)) & 3'h7];
         t.texel_x = x[12:0];
         t.texel_y = y[12:0];
         t.red = r[sel][7:0];
         t.green = g[sel][7:0];
         t.blue = b[sel][7:0];
         t.alpha = a[7:0];
         t.block_last = 1'b0;
         t.image_last = 1'b0;
         expected_texels.push_back(t);
         lastk = expected_texels.size() - 1;
      end
      if (lastk >= 0) begin
         expected_texels[lastk].block_last = 1'b1;
         expected_texels[lastk].image_last = last_block;
      end
      column_pos++;
      if (column_pos >= cols) begin
         column_pos = 0;
         row_pos++;
         if (row_pos >= rows) row_pos = 0;
      end
   endtask

   task automatic write_register(input csr_index_type idx, input logic [13:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_DXT_MODE: decode_mode = mode_type'(value[1:0]);
         CSR_IMAGE_WIDTH: width_reg = value;
         CSR_IMAGE_HEIGHT: height_reg = value;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_texels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_image(input mode_type m, input logic [13:0] w, input logic [13:0] h);
      wait_idle();
      write_register(CSR_DXT_MODE, 14'(m));
      write_register(CSR_IMAGE_WIDTH, w);
      write_register(CSR_IMAGE_HEIGHT, h);
   endtask

   task automatic send_block(input logic [63:0] cw, input logic [63:0] aw);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{color_word: cw, alpha_word: aw};
      do @(posedge clock); while (req_stall);
      predict_texels(cw, aw);
      blocks_sent++;
   endtask

   function automatic logic [13:0] pick_dimension();
      case ($urandom_range(9))
         0: return 14'd0;
         1: return 14'(DIM_LIMIT);
         2: return 14'h3FFF;
         3: return 14'($urandom_range(DIM_LIMIT + 1, 16383));
         default: return 14'($urandom_range(1, 24));
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: watchdog expired, %0d texels outstanding", $time,
                     expected_texels.size());
            $display("RESULT: ERROR");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            texels_seen++;
            if (expected_texels.size() == 0) begin
               error_count++;
               $display("%0t: unexpected texel x=%0d y=%0d", $time, rsp_data.texel_x,
                        rsp_data.texel_y);
            end else begin
               if (rsp_data !== expected_texels[0]) begin
                  error_count++;
                  $display("%0t: expected x=%0d y=%0d rgba=%h%h%h%h last=%b%b, got x=%0d y=%0d rgba=%h%h%h%h last=%b%b",
                     $time, expected_texels[0].texel_x, expected_texels[0].texel_y,
                     expected_texels[0].red, expected_texels[0].green,
                     expected_texels[0].blue, expected_texels[0].alpha,
                     expected_texels[0].block_last, expected_texels[0].image_last,
                     rsp_data.texel_x, rsp_data.texel_y, rsp_data.red, rsp_data.green,
                     rsp_data.blue, rsp_data.alpha, rsp_data.block_last,
                     rsp_data.image_last);
               end
               void'(expected_texels.pop_front());
            end
         end
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   initial begin
      block_row_type rows[$];
      int idle_plan[4][2];
      idle_plan = '{'{0, 0}, '{62, 0}, '{0, 62}, '{33, 33}};
      decode_mode = MODE_DXT1;
      width_reg = 1;
      height_reg = 1;
      column_pos = 0;
      row_pos = 0;
      rows = '{
         '{MODE_DXT1, 14'd1, 14'd1, 64'h0, 64'h0, 1'b1,
           '{13'd0, 13'd0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1}},
         '{MODE_DXT1, 14'd1, 14'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1,
           '{13'd0, 13'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1}},
         '{MODE_DXT1, 14'd1, 14'd1, 64'h0000_0000_0000_FFFF, 64'h0, 1'b1,
           '{13'd0, 13'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}},
         '{MODE_DXT3, 14'd1, 14'd1, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
           '{13'd0, 13'd0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1}},
         '{MODE_DXT3, 14'd1, 14'd1, 64'h0, 64'h0, 1'b1,
           '{13'd0, 13'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1}},
         '{MODE_DXT5, 14'd1, 14'd1, 64'h0, 64'h0, 1'b1,
           '{13'd0, 13'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1}},
         '{MODE_ALT5, 14'd1, 14'd1, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
           '{13'd0, 13'd0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1}},
         '{MODE_DXT1, 14'd0, 14'd0, 64'h0, 64'h0, 1'b1,
           '{13'd0, 13'd0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1}},
         '{MODE_DXT1, 14'd8, 14'd8, 64'hE4E4_E4E4_001F_F800, 64'h0, 1'b0, '0},
         '{MODE_DXT1, 14'd8, 14'd8, 64'h1B1B_1B1B_F800_07E0, 64'h0, 1'b0, '0},
         '{MODE_DXT3, 14'd8, 14'd8, 64'h5555_AAAA_1234_ABCD, 64'hFEDC_BA98_7654_3210,
           1'b0, '0},
         '{MODE_DXT5, 14'd6, 14'd5, 64'h0123_4567_89AB_CDEF, 64'hFAC6_88FA_C688_10F0,
           1'b0, '0},
         '{MODE_DXT5, 14'd6, 14'd5, 64'hFFFF_0000_5555_AAAA, 64'h05FA_C688_FAC6_F010,
           1'b0, '0},
         '{MODE_DXT5, 14'd6, 14'd5, 64'h3333_CCCC_7BEF_8410, 64'hFFFF_FFFF_FFFF_80FF,
           1'b0, '0},
         '{MODE_DXT5, 14'd6, 14'd5, 64'hAAAA_5555_0000_FFFF, 64'h0000_0000_0000_FF00,
           1'b0, '0},
         '{MODE_DXT5, 14'd16383, 14'd16383, 64'hFFFF_FFFF_0841_F7DE, 64'h1234_5678_9ABC_DE00,
           1'b0, '0},
         '{MODE_ALT5, 14'd8192, 14'd8192, 64'h0F0F_F0F0_C618_39E7, 64'hDB6D_B6DB_6DB6_7F80,
           1'b0, '0},
         '{MODE_DXT3, 14'd3, 14'd2, 64'hFFFF_FFFF_FFFF_FFFE, 64'h8888_7777_6666_5555,
           1'b0, '0},
         '{MODE_DXT1, 14'd3, 14'd2, 64'h0000_0000_FFFE_FFFF, 64'h0, 1'b0, '0}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_register(CSR_UNUSED, 14'h3FFF);
      foreach (rows[i]) begin
         if (rows[i].mode != decode_mode || rows[i].width != width_reg
             || rows[i].height != height_reg)
            set_image(rows[i].mode, rows[i].width, rows[i].height);
         send_block(rows[i].color_word, rows[i].alpha_word);
         if (rows[i].typed) expected_texels[expected_texels.size() - 1] = rows[i].texel;
      end
      for (int phase = 0; phase < 8; phase++) begin
         set_image(mode_type'($urandom_range(3)), pick_dimension(), pick_dimension());
         if (phase == 5) begin
            set_image(MODE_DXT5, 14'd16, 14'd16);
            hold_requests++;
         end
         sender_idle_pct = idle_plan[phase % 4][0];
         receiver_stall_pct = idle_plan[phase % 4][1];
         repeat (14) send_block({$urandom, $urandom}, {$urandom, $urandom});
      end
      receiver_stall_pct = 0;
      wait_idle();
      $display("Sent %0d blocks through DXT1, DXT3, DXT5 and the spare mode code,", blocks_sent);
      $display("checked %0d texels with clipped, zero and saturated image sizes.", texels_seen);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
design/dxt_pkg.sv
design/dxt_front.sv
design/dxt_queue.sv
design/dxt_back.sv
design/dxt_block_decoder_top.sv
test/dxt_block_decoder_top_tb.sv
